>>> src/mtacc_pkg.sv
// shared constants, types and codes of the tiled matrix multiply-accumulate unit
// no dependencies
package mtacc_pkg;

    localparam int SEQ_ROWS    = 64;
    localparam int EMBED_COLS  = 64;
    localparam int HIDDEN_COLS = 256;

    localparam int KIND_W    = 3;
    localparam int ROW_W     = 6;
    localparam int COL_W     = 8;
    localparam int DATA_W    = 16;
    localparam int ACC_W     = 40;
    localparam int TILE_W    = 8;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int BASE_W    = TILE_W + CFG_W;
    localparam int COLM_W    = BASE_W + 1;

    localparam int SR_W    = $clog2(SEQ_ROWS);
    localparam int EC_W    = $clog2(EMBED_COLS);
    localparam int HC_W    = $clog2(HIDDEN_COLS);
    localparam int W_DEPTH = EMBED_COLS * EMBED_COLS;
    localparam int X_DEPTH = SEQ_ROWS * EMBED_COLS;
    localparam int A_DEPTH = SEQ_ROWS * HIDDEN_COLS;
    localparam int W_AW    = $clog2(W_DEPTH);
    localparam int X_AW    = $clog2(X_DEPTH);
    localparam int A_AW    = $clog2(A_DEPTH);

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    localparam logic [KIND_W-1:0] KIND_LD_W   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_LD_X   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_WR_ACC = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RUN    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_RD_ACC = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 2'd2;

    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    typedef enum logic [2:0] {
        OP_LD_W,
        OP_LD_X,
        OP_WR_ACC,
        OP_RUN,
        OP_RD_ACC
    } t_op;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_WAIT,
        ST_MAC,
        ST_DRAIN,
        ST_ACC_RD,
        ST_ACC_WR,
        ST_NEXT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [CFG_W-1:0] rows;
        logic [CFG_W-1:0] inner;
        logic [CFG_W-1:0] cols;
    } t_cfg;

    typedef struct packed {
        t_op                op;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic [DATA_W-1:0]  data;
        logic [ACC_W-1:0]   acc;
        logic [TILE_W-1:0]  tile;
    } t_entry;

    function automatic logic [CFG_W-1:0] clamp_to(input logic [CFG_W-1:0] v, input int lim);
        logic [CFG_W-1:0] r;
        r = (int'(v) > lim) ? CFG_W'(lim) : v;
        return r;
    endfunction

endpackage

>>> src/mtacc_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module mtacc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/mtacc_front.sv
// front end: accepts input words, classifies them and queues them for the back end
// depends on mtacc_pkg
module mtacc_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_enable,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [mtacc_pkg::KIND_W-1:0]  i_kind,
    input  logic [mtacc_pkg::ROW_W-1:0]   i_row,
    input  logic [mtacc_pkg::COL_W-1:0]   i_col,
    input  logic [mtacc_pkg::DATA_W-1:0]  i_data,
    input  logic [mtacc_pkg::ACC_W-1:0]   i_acc,
    input  logic [mtacc_pkg::TILE_W-1:0]  i_tile,
    output logic                          o_q_valid,
    output mtacc_pkg::t_entry             o_q_entry,
    input  logic                          i_q_pop
);

    mtacc_pkg::t_entry               r_q [mtacc_pkg::Q_DEPTH];
    logic [mtacc_pkg::Q_AW-1:0]      r_wptr;
    logic [mtacc_pkg::Q_AW-1:0]      r_rptr;
    logic [mtacc_pkg::Q_AW:0]        r_count;
    mtacc_pkg::t_entry               n_entry;
    logic                            n_keep;
    logic                            n_push;
    logic                            n_pop;

    // classify: drop unknown kinds and out-of-range loads and writes
    always_comb begin
        n_keep        = 1'b0;
        n_entry.op    = mtacc_pkg::OP_RUN;
        n_entry.row   = i_row;
        n_entry.col   = i_col;
        n_entry.data  = i_data;
        n_entry.acc   = i_acc;
        n_entry.tile  = i_tile;
        case (i_kind)
            mtacc_pkg::KIND_LD_W: begin
                n_entry.op = mtacc_pkg::OP_LD_W;
                n_keep     = (int'(i_row) < mtacc_pkg::EMBED_COLS)
                          && (int'(i_col) < mtacc_pkg::EMBED_COLS);
            end
            mtacc_pkg::KIND_LD_X: begin
                n_entry.op = mtacc_pkg::OP_LD_X;
                n_keep     = (int'(i_row) < mtacc_pkg::SEQ_ROWS)
                          && (int'(i_col) < mtacc_pkg::EMBED_COLS);
            end
            mtacc_pkg::KIND_WR_ACC: begin
                n_entry.op = mtacc_pkg::OP_WR_ACC;
                n_keep     = (int'(i_row) < mtacc_pkg::SEQ_ROWS)
                          && (int'(i_col) < mtacc_pkg::HIDDEN_COLS);
            end
            mtacc_pkg::KIND_RUN: begin
                n_entry.op = mtacc_pkg::OP_RUN;
                n_keep     = 1'b1;
            end
            mtacc_pkg::KIND_RD_ACC: begin
                n_entry.op = mtacc_pkg::OP_RD_ACC;
                n_keep     = 1'b1;
            end
            default: begin
                n_keep = 1'b0;
            end
        endcase
    end

    assign o_in_ready = i_enable && (int'(r_count) < mtacc_pkg::Q_DEPTH);
    assign n_push     = i_in_valid && o_in_ready && n_keep;
    assign n_pop      = i_q_pop && o_q_valid;
    assign o_q_valid  = (r_count != '0);
    assign o_q_entry  = r_q[r_rptr];

    always_ff @(posedge i_clk) begin
        if (n_push) begin
            r_q[r_wptr] <= n_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (n_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (n_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({n_push, n_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> src/mtacc_back.sv
// back end: executes queued words against the weight, input and accumulator memories
// depends on mtacc_pkg and mtacc_ram
module mtacc_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mtacc_pkg::t_cfg               i_cfg,
    input  logic                          i_q_valid,
    input  mtacc_pkg::t_entry             i_q_entry,
    output logic                          o_q_pop,
    output logic                          o_enable,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [mtacc_pkg::ACC_W-1:0]   o_read_value,
    output logic                          o_run_done,
    output logic                          o_range_error
);

    mtacc_pkg::t_state                r_state, n_state;
    logic [mtacc_pkg::A_AW-1:0]       r_clr, n_clr;
    logic [mtacc_pkg::CFG_W-1:0]      r_s, n_s, r_n, n_n, r_k, n_k;
    logic [mtacc_pkg::CFG_W-1:0]      r_l, n_l, r_i, n_i, r_j, n_j;
    logic [mtacc_pkg::BASE_W-1:0]     r_base, n_base;
    logic                             r_p1, n_p1, r_p2, n_p2;
    logic signed [mtacc_pkg::PROD_W-1:0] r_prod, n_prod;
    logic [mtacc_pkg::ACC_W-1:0]      r_sum, n_sum;
    logic                             r_err, n_err;
    logic                             r_out_valid, n_out_valid;
    logic [mtacc_pkg::ACC_W-1:0]      r_out_value, n_out_value;
    logic                             r_out_done, n_out_done;
    logic                             r_out_err, n_out_err;

    logic                             w_we, w_re, x_we, x_re, a_we, a_re;
    logic [mtacc_pkg::W_AW-1:0]       w_waddr, w_raddr;
    logic [mtacc_pkg::X_AW-1:0]       x_waddr, x_raddr;
    logic [mtacc_pkg::A_AW-1:0]       a_waddr, a_raddr;
    logic [mtacc_pkg::ACC_W-1:0]      a_wdata;
    logic [mtacc_pkg::DATA_W-1:0]     w_rdata, x_rdata;
    logic [mtacc_pkg::ACC_W-1:0]      a_rdata;
    logic [mtacc_pkg::COLM_W-1:0]     n_m;
    logic                             n_out_free;
    logic [mtacc_pkg::CFG_W-1:0]      n_cs, n_ck;

    mtacc_ram #(.WIDTH(mtacc_pkg::DATA_W), .DEPTH(mtacc_pkg::W_DEPTH)) u_wram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(i_q_entry.data),
        .i_re(w_re), .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    mtacc_ram #(.WIDTH(mtacc_pkg::DATA_W), .DEPTH(mtacc_pkg::X_DEPTH)) u_xram (
        .i_clk(i_clk), .i_we(x_we), .i_waddr(x_waddr), .i_wdata(i_q_entry.data),
        .i_re(x_re), .i_raddr(x_raddr), .o_rdata(x_rdata)
    );

    mtacc_ram #(.WIDTH(mtacc_pkg::ACC_W), .DEPTH(mtacc_pkg::A_DEPTH)) u_aram (
        .i_clk(i_clk), .i_we(a_we), .i_waddr(a_waddr), .i_wdata(a_wdata),
        .i_re(a_re), .i_raddr(a_raddr), .o_rdata(a_rdata)
    );

    assign n_out_free = !r_out_valid || i_out_ready;
    assign n_m        = mtacc_pkg::COLM_W'(r_base) + mtacc_pkg::COLM_W'(r_i);
    assign n_cs       = mtacc_pkg::clamp_to(i_cfg.rows, mtacc_pkg::SEQ_ROWS);
    assign n_ck       = mtacc_pkg::clamp_to(i_cfg.cols, mtacc_pkg::EMBED_COLS);

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_s         = r_s;
        n_n         = r_n;
        n_k         = r_k;
        n_l         = r_l;
        n_i         = r_i;
        n_j         = r_j;
        n_base      = r_base;
        n_err       = r_err;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_value = r_out_value;
        n_out_done  = r_out_done;
        n_out_err   = r_out_err;
        o_q_pop     = 1'b0;
        w_we        = 1'b0;
        x_we        = 1'b0;
        a_we        = 1'b0;
        w_re        = 1'b0;
        x_re        = 1'b0;
        a_re        = 1'b0;
        w_waddr     = {i_q_entry.row[mtacc_pkg::EC_W-1:0], i_q_entry.col[mtacc_pkg::EC_W-1:0]};
        x_waddr     = {i_q_entry.row[mtacc_pkg::SR_W-1:0], i_q_entry.col[mtacc_pkg::EC_W-1:0]};
        w_raddr     = {r_i[mtacc_pkg::EC_W-1:0], r_j[mtacc_pkg::EC_W-1:0]};
        x_raddr     = {r_l[mtacc_pkg::SR_W-1:0], r_j[mtacc_pkg::EC_W-1:0]};
        a_waddr     = {r_l[mtacc_pkg::SR_W-1:0], n_m[mtacc_pkg::HC_W-1:0]};
        a_raddr     = {r_l[mtacc_pkg::SR_W-1:0], n_m[mtacc_pkg::HC_W-1:0]};
        a_wdata     = a_rdata + r_sum;

        // multiply-accumulate pipeline: read, product, sum
        n_p1   = 1'b0;
        n_p2   = r_p1;
        n_prod = r_p1 ? $signed(x_rdata) * $signed(w_rdata) : r_prod;
        n_sum  = r_p2 ? r_sum + mtacc_pkg::ACC_W'(r_prod) : r_sum;

        case (r_state)
            mtacc_pkg::ST_CLEAR: begin
                a_we    = 1'b1;
                a_waddr = r_clr;
                a_wdata = '0;
                n_clr   = r_clr + 1'b1;
                if (int'(r_clr) == mtacc_pkg::A_DEPTH - 1) begin
                    n_state = mtacc_pkg::ST_IDLE;
                end
            end
            mtacc_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    a_waddr = {i_q_entry.row[mtacc_pkg::SR_W-1:0],
                               i_q_entry.col[mtacc_pkg::HC_W-1:0]};
                    a_raddr = a_waddr;
                    case (i_q_entry.op)
                        mtacc_pkg::OP_LD_W: w_we = 1'b1;
                        mtacc_pkg::OP_LD_X: x_we = 1'b1;
                        mtacc_pkg::OP_WR_ACC: begin
                            a_we    = 1'b1;
                            a_wdata = i_q_entry.acc;
                        end
                        mtacc_pkg::OP_RD_ACC: begin
                            a_re    = 1'b1;
                            n_state = mtacc_pkg::ST_RD_WAIT;
                        end
                        mtacc_pkg::OP_RUN: begin
                            n_s    = n_cs;
                            n_n    = mtacc_pkg::clamp_to(i_cfg.inner, mtacc_pkg::EMBED_COLS);
                            n_k    = n_ck;
                            n_base = mtacc_pkg::BASE_W'(i_q_entry.tile)
                                   * mtacc_pkg::BASE_W'(i_cfg.cols);
                            n_l    = '0;
                            n_i    = '0;
                            n_j    = '0;
                            n_sum  = '0;
                            n_err  = 1'b0;
                            if (n_cs == '0 || n_ck == '0) begin
                                n_state = mtacc_pkg::ST_DONE;
                            end else begin
                                n_state = mtacc_pkg::ST_MAC;
                            end
                        end
                        default: n_state = mtacc_pkg::ST_IDLE;
                    endcase
                end
            end
            mtacc_pkg::ST_RD_WAIT: begin
                if (n_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_value = a_rdata;
                    n_out_done  = 1'b0;
                    n_out_err   = 1'b0;
                    n_state     = mtacc_pkg::ST_IDLE;
                end
            end
            mtacc_pkg::ST_MAC: begin
                if (r_j < r_n) begin
                    w_re = 1'b1;
                    x_re = 1'b1;
                    n_p1 = 1'b1;
                    n_j  = r_j + 1'b1;
                end else begin
                    n_state = mtacc_pkg::ST_DRAIN;
                end
            end
            mtacc_pkg::ST_DRAIN: begin
                if (!r_p1 && !r_p2) begin
                    n_state = mtacc_pkg::ST_ACC_RD;
                end
            end
            mtacc_pkg::ST_ACC_RD: begin
                if (int'(n_m) < mtacc_pkg::HIDDEN_COLS) begin
                    a_re    = 1'b1;
                    n_state = mtacc_pkg::ST_ACC_WR;
                end else begin
                    n_err   = 1'b1;
                    n_state = mtacc_pkg::ST_NEXT;
                end
            end
            mtacc_pkg::ST_ACC_WR: begin
                a_we    = 1'b1;
                n_state = mtacc_pkg::ST_NEXT;
            end
            mtacc_pkg::ST_NEXT: begin
                n_sum   = '0;
                n_j     = '0;
                n_state = mtacc_pkg::ST_MAC;
                if (r_i + 1'b1 < r_k) begin
                    n_i = r_i + 1'b1;
                end else begin
                    n_i = '0;
                    if (r_l + 1'b1 < r_s) begin
                        n_l = r_l + 1'b1;
                    end else begin
                        n_state = mtacc_pkg::ST_DONE;
                    end
                end
            end
            mtacc_pkg::ST_DONE: begin
                if (n_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_value = '0;
                    n_out_done  = 1'b1;
                    n_out_err   = r_err;
                    n_state     = mtacc_pkg::ST_IDLE;
                end
            end
            default: n_state = mtacc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mtacc_pkg::ST_CLEAR;
            r_clr       <= '0;
            r_p1        <= 1'b0;
            r_p2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_p1        <= n_p1;
            r_p2        <= n_p2;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s         <= n_s;
        r_n         <= n_n;
        r_k         <= n_k;
        r_l         <= n_l;
        r_i         <= n_i;
        r_j         <= n_j;
        r_base      <= n_base;
        r_prod      <= n_prod;
        r_sum       <= n_sum;
        r_err       <= n_err;
        r_out_value <= n_out_value;
        r_out_done  <= n_out_done;
        r_out_err   <= n_out_err;
    end

    assign o_enable      = (r_state != mtacc_pkg::ST_CLEAR);
    assign o_out_valid   = r_out_valid;
    assign o_read_value  = r_out_value;
    assign o_run_done    = r_out_done;
    assign o_range_error = r_out_err;

endmodule

>>> src/matmul_tile_accumulate_unit.sv
// tiled matrix multiply-accumulate unit: top level with configuration registers
// depends on mtacc_pkg, mtacc_front, mtacc_back
// load and write words are executed as they are popped; a read result is registered and waits for a free output word
// a run holds the back end until its tile is done; a column past the accumulator is skipped and flagged
// after reset the accumulator memory is zeroed with the input held off
// reset is synchronous active low and clears control state and configuration to 64
module matmul_tile_accumulate_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [mtacc_pkg::KIND_W-1:0]     i_kind,
    input  logic [mtacc_pkg::ROW_W-1:0]      i_row,
    input  logic [mtacc_pkg::COL_W-1:0]      i_col,
    input  logic signed [mtacc_pkg::DATA_W-1:0] i_data_value,
    input  logic signed [mtacc_pkg::ACC_W-1:0]  i_acc_value,
    input  logic [mtacc_pkg::TILE_W-1:0]     i_tile_index,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic signed [mtacc_pkg::ACC_W-1:0]  o_read_value,
    output logic                             o_run_done,
    output logic                             o_range_error,
    input  logic                             i_cfg_we,
    input  logic [mtacc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mtacc_pkg::CFG_W-1:0]      i_cfg_data
);

    mtacc_pkg::t_cfg    r_cfg;
    mtacc_pkg::t_entry  q_entry;
    logic               q_valid;
    logic               q_pop;
    logic               enable;
    logic [mtacc_pkg::ACC_W-1:0] read_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rows  <= mtacc_pkg::CFG_RESET;
            r_cfg.inner <= mtacc_pkg::CFG_RESET;
            r_cfg.cols  <= mtacc_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mtacc_pkg::CFG_ROWS:  r_cfg.rows  <= i_cfg_data;
                mtacc_pkg::CFG_INNER: r_cfg.inner <= i_cfg_data;
                mtacc_pkg::CFG_COLS:  r_cfg.cols  <= i_cfg_data;
                default:              r_cfg       <= r_cfg;
            endcase
        end
    end

    mtacc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_enable   (enable),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_kind     (i_kind),
        .i_row      (i_row),
        .i_col      (i_col),
        .i_data     (i_data_value),
        .i_acc      (i_acc_value),
        .i_tile     (i_tile_index),
        .o_q_valid  (q_valid),
        .o_q_entry  (q_entry),
        .i_q_pop    (q_pop)
    );

    mtacc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_q_valid     (q_valid),
        .i_q_entry     (q_entry),
        .o_q_pop       (q_pop),
        .o_enable      (enable),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_read_value  (read_value),
        .o_run_done    (o_run_done),
        .o_range_error (o_range_error)
    );

    assign o_read_value = $signed(read_value);

endmodule

>>> src/mtacc_checker.sv
// port-level checks of the tiled matrix multiply-accumulate unit, bound to the top level
// depends on mtacc_pkg
module mtacc_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             o_in_ready,
    input  logic [mtacc_pkg::KIND_W-1:0]     i_kind,
    input  logic [mtacc_pkg::ROW_W-1:0]      i_row,
    input  logic [mtacc_pkg::COL_W-1:0]      i_col,
    input  logic signed [mtacc_pkg::DATA_W-1:0] i_data_value,
    input  logic signed [mtacc_pkg::ACC_W-1:0]  i_acc_value,
    input  logic [mtacc_pkg::TILE_W-1:0]     i_tile_index,
    input  logic                             o_out_valid,
    input  logic                             i_out_ready,
    input  logic signed [mtacc_pkg::ACC_W-1:0]  o_read_value,
    input  logic                             o_run_done,
    input  logic                             o_range_error,
    input  logic                             i_cfg_we,
    input  logic [mtacc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mtacc_pkg::CFG_W-1:0]      i_cfg_data
);

    // result word holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result word dropped before accept");

    a_run_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_run_done |-> o_read_value == '0)
        else $error("run result carries a value");

    a_read_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_run_done |-> !o_range_error)
        else $error("in-range read flagged");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result word after reset");

    // accumulator clear holds input off after reset
    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("input taken during clear");

endmodule

bind matmul_tile_accumulate_unit mtacc_checker u_mtacc_checker (.*);
